// ===== hdl/qee_pkg.sv =====
package qee_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int ADDR_W       = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int VTX_W        = 10;
    localparam int NQ           = 10;
    localparam int ENTRY_W      = 48;

    typedef logic [NQ-1:0][ENTRY_W-1:0] row_t;

    // row and column of each unique quadric entry
    function automatic logic [1:0] pair_row(input logic [3:0] k);
        logic [1:0] r;
        case (k)
            4'd0, 4'd1, 4'd2, 4'd3: r = 2'd0;
            4'd4, 4'd5, 4'd6:       r = 2'd1;
            4'd7, 4'd8:             r = 2'd2;
            default:                r = 2'd3;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] pair_col(input logic [3:0] k);
        logic [1:0] c;
        case (k)
            4'd0:             c = 2'd0;
            4'd1, 4'd4:       c = 2'd1;
            4'd2, 4'd5, 4'd7: c = 2'd2;
            default:          c = 2'd3;
        endcase
        return c;
    endfunction

    function automatic logic signed [ENTRY_W-1:0] sat48(input logic signed [ENTRY_W:0] v);
        logic signed [ENTRY_W-1:0] r;
        if (v[ENTRY_W] != v[ENTRY_W-1])
            r = v[ENTRY_W] ? {1'b1, {(ENTRY_W-1){1'b0}}} : {1'b0, {(ENTRY_W-1){1'b1}}};
        else
            r = v[ENTRY_W-1:0];
        return r;
    endfunction

endpackage

// ===== hdl/quadric_error_edge_cost.sv =====
// Accumulate item: dot product, ten entry updates and write-back before the next item.
// Evaluate item: reads both rows, weights each quadric entry, rounds, shows the result.
// Throughput: one item at a time; every product goes through one shared 25x35 multiplier.
// Store memory is one row of ten entries per vertex, one read and one write port.
// After reset a clearing pass zeroes the store, one row a cycle,
// with input stalled throughout; the result channel resets to empty.
module quadric_error_edge_cost (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               operation,
    input  logic [9:0]         first_vertex,
    input  logic [9:0]         second_vertex,
    input  logic signed [15:0] normal_x,
    input  logic signed [15:0] normal_y,
    input  logic signed [15:0] normal_z,
    input  logic signed [15:0] pos_a_x,
    input  logic signed [15:0] pos_a_y,
    input  logic signed [15:0] pos_a_z,
    input  logic signed [15:0] pos_b_x,
    input  logic signed [15:0] pos_b_y,
    input  logic signed [15:0] pos_b_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [47:0]        edge_error
);
    import qee_pkg::*;

    localparam logic [16:0] VTX_LIMIT = 17'(MAX_VERTICES);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_VERTICES - 1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD_A, S_RD_B, S_LD_B, S_DOT, S_MKD, S_ACC, S_WB,
        S_EVAL, S_RND, S_FIN
    } state_t;

    state_t state_reg;
    logic [ADDR_W-1:0] clr_reg;
    logic [3:0] k_reg;
    logic [1:0] ph_reg;
    logic op_reg;
    logic [VTX_W-1:0] u_reg, w_reg;
    logic signed [15:0] n_reg [3];
    logic signed [15:0] pa_reg [3];
    logic signed [16:0] s_reg [3];
    logic signed [33:0] dot_reg;
    logic signed [18:0] d_reg;
    logic signed [34:0] t_reg;
    logic signed [47:0] qsum_reg;
    logic signed [87:0] acc_reg;
    row_t row_a_reg, row_b_reg;
    logic out_valid_reg;
    logic [47:0] result_reg;

    // store
    row_t mem [MAX_VERTICES];
    row_t rd_data;
    logic mem_we;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    row_t mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data <= mem[mem_raddr];
    end

    logic in_range_u, in_range_w;
    assign in_range_u = (17'(u_reg) < VTX_LIMIT);
    assign in_range_w = (17'(w_reg) < VTX_LIMIT);

    logic [1:0] kr, kc;
    assign kr = pair_row(k_reg);
    assign kc = pair_col(k_reg);

    logic signed [18:0] p_r, p_c;
    logic signed [16:0] s_r, s_c;
    always_comb
    begin
        p_r = (kr == 2'd3) ? d_reg : 19'(n_reg[kr]);
        p_c = (kc == 2'd3) ? d_reg : 19'(n_reg[kc]);
        s_r = (kr == 2'd3) ? 17'sd32768 : s_reg[kr];
        s_c = (kc == 2'd3) ? 17'sd32768 : s_reg[kc];
    end

    // shared multiplier
    logic signed [24:0] mul_a;
    logic signed [34:0] mul_b;
    logic signed [59:0] mul_p;
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_DOT:
            begin
                mul_a = 25'(n_reg[k_reg[1:0]]);
                mul_b = 35'(pa_reg[k_reg[1:0]]);
            end
            S_ACC:
            begin
                mul_a = 25'(p_r);
                mul_b = 35'(p_c);
            end
            S_EVAL:
            begin
                unique case (ph_reg)
                    2'd0:
                    begin
                        mul_a = 25'(s_r);
                        mul_b = 35'(s_c);
                    end
                    2'd1:
                    begin
                        mul_a = $signed({1'b0, qsum_reg[23:0]});
                        mul_b = t_reg;
                    end
                    default:
                    begin
                        mul_a = 25'($signed(qsum_reg[47:24]));
                        mul_b = t_reg;
                    end
                endcase
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    logic signed [48:0] acc_sum;
    logic signed [48:0] pair_sum;
    logic signed [34:0] neg_dot;
    assign acc_sum  = 49'($signed(row_a_reg[k_reg])) + 49'(mul_p);
    assign pair_sum = 49'($signed(row_a_reg[k_reg])) + 49'($signed(row_b_reg[k_reg]));
    assign neg_dot  = -35'(dot_reg) + 35'sd8192;

    logic in_accept;
    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign edge_error = result_reg;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = clr_reg;
        mem_wdata = '0;
        mem_raddr = ADDR_W'(u_reg);
        if (state_reg == S_CLEAR)
            mem_we = 1'b1;
        else if (state_reg == S_WB)
        begin
            mem_we    = in_range_u;
            mem_waddr = ADDR_W'(u_reg);
            mem_wdata = row_a_reg;
        end
        if (state_reg == S_RD_B)
            mem_raddr = ADDR_W'(w_reg);
    end

    logic [47:0] final_err;
    always_comb
    begin
        if (acc_reg[87])
            final_err = '0;
        else if (|acc_reg[86:78])
            final_err = '1;
        else
            final_err = acc_reg[77:30];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            k_reg         <= '0;
            ph_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // the finish state drives the result valid itself
            if (out_valid_reg && !out_stall && state_reg != S_FIN)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == LAST_ADDR)
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        op_reg    <= operation;
                        u_reg     <= first_vertex;
                        w_reg     <= second_vertex;
                        n_reg[0]  <= normal_x;
                        n_reg[1]  <= normal_y;
                        n_reg[2]  <= normal_z;
                        pa_reg[0] <= pos_a_x;
                        pa_reg[1] <= pos_a_y;
                        pa_reg[2] <= pos_a_z;
                        s_reg[0]  <= 17'(pos_a_x) + 17'(pos_b_x);
                        s_reg[1]  <= 17'(pos_a_y) + 17'(pos_b_y);
                        s_reg[2]  <= 17'(pos_a_z) + 17'(pos_b_z);
                        state_reg <= S_RD_A;
                    end
                end
                S_RD_A:
                begin
                    k_reg     <= '0;
                    dot_reg   <= '0;
                    state_reg <= op_reg ? S_RD_B : S_DOT;
                end
                S_RD_B:
                begin
                    row_a_reg <= in_range_u ? rd_data : '0;
                    state_reg <= S_LD_B;
                end
                S_LD_B:
                begin
                    row_b_reg <= in_range_w ? rd_data : '0;
                    acc_reg   <= '0;
                    k_reg     <= '0;
                    ph_reg    <= '0;
                    state_reg <= S_EVAL;
                end
                S_DOT:
                begin
                    if (k_reg == 4'd0)
                        row_a_reg <= in_range_u ? rd_data : '0;
                    dot_reg <= dot_reg + 34'(mul_p);
                    if (k_reg == 4'd2)
                    begin
                        k_reg     <= '0;
                        state_reg <= S_MKD;
                    end
                    else
                        k_reg <= k_reg + 1'b1;
                end
                S_MKD:
                begin
                    d_reg     <= 19'(neg_dot >>> 14);
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    row_a_reg[k_reg] <= sat48(acc_sum);
                    if (k_reg == 4'(NQ - 1))
                    begin
                        k_reg     <= '0;
                        state_reg <= S_WB;
                    end
                    else
                        k_reg <= k_reg + 1'b1;
                end
                S_WB:
                    state_reg <= S_IDLE;
                S_EVAL:
                begin
                    unique case (ph_reg)
                        2'd0:
                        begin
                            // off-diagonal entries appear twice in the form
                            t_reg    <= (kr == kc) ? 35'(mul_p) : 35'(mul_p) <<< 1;
                            qsum_reg <= sat48(pair_sum);
                            ph_reg   <= 2'd1;
                        end
                        2'd1:
                        begin
                            acc_reg <= acc_reg + 88'(mul_p);
                            ph_reg  <= 2'd2;
                        end
                        default:
                        begin
                            acc_reg <= acc_reg + (88'(mul_p) <<< 24);
                            ph_reg  <= 2'd0;
                            if (k_reg == 4'(NQ - 1))
                            begin
                                k_reg     <= '0;
                                state_reg <= S_RND;
                            end
                            else
                                k_reg <= k_reg + 1'b1;
                        end
                    endcase
                end
                S_RND:
                begin
                    acc_reg   <= acc_reg + (88'sd1 <<< 29);
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    // hold until the previous result has gone
                    if (!out_valid_reg || !out_stall)
                    begin
                        result_reg    <= final_err;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_CLEAR || state_reg == S_WB))
        else $error("store written outside clear or write-back");

    a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("result raised outside finish");

    a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> in_stall)
        else $error("item accepted during clearing pass");

    a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
        k_reg < 4'(NQ))
        else $error("entry counter out of range");

    a_acc_no_out: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WB |=> !$rose(out_valid_reg))
        else $error("accumulate produced a result");

endmodule
